// ===== rtl/deck_line_cleaner_unit_defines.svh =====
// assertion macros of the deck line cleaner rtl
`ifndef DECK_LINE_CLEANER_UNIT_DEFINES_SVH
`define DECK_LINE_CLEANER_UNIT_DEFINES_SVH

// condition must never hold outside reset
`define DLC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define DLC_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DLC_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dlc_pkg.sv =====
// shared types, character codes and helpers of the deck line cleaner
package dlc_pkg;

  localparam int unsigned DLC_PENDING_DEPTH = 32;
  localparam int unsigned DLC_QUEUE_DEPTH   = 4;

  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // work list for one request, built by the front end
  typedef struct packed {
    logic       dash1;  // keep a held dash before the byte
    logic       keep2;  // keep the byte itself
    logic [7:0] chr;
    logic       dash3;  // keep a held dash before closing the line
    logic       endl;   // close the line
  } dlc_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dlc_q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DASH1,
    BK_KEEP2,
    BK_DASH3,
    BK_NL,
    BK_FIN
  } bk_state_t;

  // first step still to do for a work list
  function automatic bk_state_t first_step(dlc_rec_t r);
    bk_state_t s;
    priority if (r.dash1) s = BK_DASH1;
    else if (r.keep2)     s = BK_KEEP2;
    else if (r.dash3)     s = BK_DASH3;
    else if (r.endl)      s = BK_NL;
    else                  s = BK_FIN;
    return s;
  endfunction

endpackage

// ===== rtl/dlc_stream_if.sv =====
// valid/ready stream interfaces of the deck line cleaner
interface dlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface dlc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       pending_overflow;

  modport source (output valid, output out_byte, output last_of_run,
                  output pending_overflow, input ready);
  modport sink (input valid, input out_byte, input last_of_run,
                input pending_overflow, output ready);
endinterface

// ===== rtl/dlc_queue.sv =====
// small fifo of work lists between front and back end
module dlc_queue
  import dlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  dlc_rec_t    push_data,
  input  logic        pop,
  output dlc_rec_t    pop_data,
  output dlc_q_stat_t stat
);

  localparam int unsigned PTR_W = $clog2(DLC_QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(DLC_QUEUE_DEPTH + 1);

  dlc_rec_t           slots_r [DLC_QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNT_W'(DLC_QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/dlc_front.sv =====
// front end: takes text bytes, tracks quote and comment state, builds work lists
module dlc_front
  import dlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dlc_in_if.sink      in_if,
  input  dlc_q_stat_t q_stat,
  output logic        push,
  output dlc_rec_t    rec
);

  logic in_quote_r, in_quote_nxt;
  logic quote_dbl_r, quote_dbl_nxt;
  logic dash_held_r, dash_held_nxt;
  logic discard_r, discard_nxt;
  logic acc;
  logic [7:0] b;
  logic eot;

  assign in_if.ready = !q_stat.full;
  assign acc = in_if.valid && in_if.ready;
  assign b   = in_if.text_byte;
  assign eot = in_if.end_of_text;

  always_comb begin
    in_quote_nxt  = in_quote_r;
    quote_dbl_nxt = quote_dbl_r;
    dash_held_nxt = dash_held_r;
    discard_nxt   = discard_r;
    rec           = '0;
    rec.chr       = b;

    priority if (b == CH_NL) begin
      rec.endl      = 1'b1;
      rec.dash3     = dash_held_r;
      in_quote_nxt  = 1'b0;
      quote_dbl_nxt = 1'b0;
      dash_held_nxt = 1'b0;
      discard_nxt   = 1'b0;
    end else if (discard_r) begin
      // rest of line dropped
    end else if (in_quote_r) begin
      rec.keep2 = 1'b1;
      if (b == (quote_dbl_r ? CH_DQUOTE : CH_SQUOTE)) begin
        in_quote_nxt = 1'b0;
      end
    end else if (dash_held_r && b == CH_DASH) begin
      // double dash starts a comment
      dash_held_nxt = 1'b0;
      discard_nxt   = 1'b1;
    end else begin
      rec.dash1     = dash_held_r;
      dash_held_nxt = 1'b0;
      priority if (b == CH_DASH) begin
        dash_held_nxt = 1'b1;
      end else if (b == CH_SLASH) begin
        rec.keep2   = 1'b1;
        discard_nxt = 1'b1;
      end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
        rec.keep2     = 1'b1;
        in_quote_nxt  = 1'b1;
        quote_dbl_nxt = (b == CH_DQUOTE);
      end else begin
        rec.keep2 = 1'b1;
      end
    end

    // end of text on an open line closes it
    if (eot && b != CH_NL) begin
      rec.endl      = 1'b1;
      rec.dash3     = dash_held_nxt;
      in_quote_nxt  = 1'b0;
      quote_dbl_nxt = 1'b0;
      dash_held_nxt = 1'b0;
      discard_nxt   = 1'b0;
    end

    push = acc && (rec.dash1 || rec.keep2 || rec.endl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quote_r  <= 1'b0;
      quote_dbl_r <= 1'b0;
      dash_held_r <= 1'b0;
      discard_r   <= 1'b0;
    end else if (acc) begin
      in_quote_r  <= in_quote_nxt;
      quote_dbl_r <= quote_dbl_nxt;
      dash_held_r <= dash_held_nxt;
      discard_r   <= discard_nxt;
    end
  end

endmodule

// ===== rtl/dlc_back.sv =====
// back end: runs work lists against the pending separator ring and emits bytes
module dlc_back
  import dlc_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = DLC_PENDING_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dlc_q_stat_t q_stat,
  input  dlc_rec_t    q_data,
  output logic        pop,
  dlc_out_if.source   out_if
);

  localparam int unsigned IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(PENDING_DEPTH + 1);

  bk_state_t        state_r, state_nxt;
  dlc_rec_t         it_r, it_nxt;
  logic             ls_r, ls_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // last result is held back until it is known whether it closes the request
  logic             hold_v_r, hold_v_nxt;
  logic [7:0]       hold_chr_r, hold_chr_nxt;
  logic             hold_ovf_r, hold_ovf_nxt;

  logic             out_v_r, out_v_nxt;
  logic [7:0]       out_chr_r, out_chr_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic [7:0]       ring [PENDING_DEPTH];
  logic [7:0]       rd_data_r;
  logic             wr_en;
  logic [7:0]       wr_data;

  logic             push_ok, emit_ok, emit, emit_ovf, step_done, load;
  logic [7:0]       emit_chr, cur;

  function automatic logic is_sep(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR;
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(logic [IDX_W-1:0] p);
    return (p == IDX_W'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ok = !out_v_r || out_if.ready;
  assign emit_ok = !hold_v_r || push_ok;
  assign cur     = (state_r == BK_KEEP2) ? it_r.chr : CH_DASH;

  always_comb begin
    state_nxt    = state_r;
    it_nxt       = it_r;
    ls_nxt       = ls_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    hold_v_nxt   = hold_v_r;
    hold_chr_nxt = hold_chr_r;
    hold_ovf_nxt = hold_ovf_r;
    out_v_nxt    = out_v_r && !out_if.ready;
    out_chr_nxt  = out_chr_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;
    wr_en        = 1'b0;
    wr_data      = cur;
    emit         = 1'b0;
    emit_chr     = cur;
    emit_ovf     = 1'b0;
    step_done    = 1'b0;
    load         = 1'b0;
    pop          = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        load = 1'b1;
      end
      BK_DASH1, BK_KEEP2, BK_DASH3: begin
        if (is_sep(cur)) begin
          priority if (!ls_r) begin
            step_done = 1'b1;
          end else if (cnt_r == CNT_W'(PENDING_DEPTH)) begin
            // ring full: oldest separator leaves early, flagged
            if (emit_ok) begin
              emit      = 1'b1;
              emit_chr  = rd_data_r;
              emit_ovf  = 1'b1;
              head_nxt  = idx_inc(head_r);
              wr_en     = 1'b1;
              tail_nxt  = idx_inc(tail_r);
              step_done = 1'b1;
            end
          end else begin
            wr_en     = 1'b1;
            tail_nxt  = idx_inc(tail_r);
            cnt_nxt   = cnt_r + 1'b1;
            step_done = 1'b1;
          end
        end else if (cnt_r != '0) begin
          // drain held separators one a cycle while the output can take them
          if (emit_ok) begin
            emit     = 1'b1;
            emit_chr = rd_data_r;
            head_nxt = idx_inc(head_r);
            cnt_nxt  = cnt_r - 1'b1;
          end
        end else if (emit_ok) begin
          emit      = 1'b1;
          ls_nxt    = 1'b1;
          step_done = 1'b1;
        end
      end
      BK_NL: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_chr  = CH_NL;
          ls_nxt    = 1'b0;
          cnt_nxt   = '0;
          head_nxt  = '0;
          tail_nxt  = '0;
          step_done = 1'b1;
        end
      end
      BK_FIN: begin
        if (!hold_v_r || push_ok) begin
          if (hold_v_r) begin
            out_v_nxt    = 1'b1;
            out_chr_nxt  = hold_chr_r;
            out_ovf_nxt  = hold_ovf_r;
            out_last_nxt = 1'b1;
            hold_v_nxt   = 1'b0;
          end
          load = 1'b1;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (step_done) begin
      unique case (state_r)
        BK_DASH1: it_nxt.dash1 = 1'b0;
        BK_KEEP2: it_nxt.keep2 = 1'b0;
        BK_DASH3: it_nxt.dash3 = 1'b0;
        default:  it_nxt.endl  = 1'b0;
      endcase
      state_nxt = first_step(it_nxt);
    end

    if (emit) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_chr_nxt  = hold_chr_r;
        out_ovf_nxt  = hold_ovf_r;
        out_last_nxt = 1'b0;
      end
      hold_v_nxt   = 1'b1;
      hold_chr_nxt = emit_chr;
      hold_ovf_nxt = emit_ovf;
    end

    if (load) begin
      if (!q_stat.empty) begin
        pop       = 1'b1;
        it_nxt    = q_data;
        state_nxt = first_step(q_data);
      end else begin
        state_nxt = BK_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      ls_r     <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      cnt_r    <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ls_r     <= ls_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      cnt_r    <= cnt_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r       <= it_nxt;
    hold_chr_r <= hold_chr_nxt;
    hold_ovf_r <= hold_ovf_nxt;
    out_chr_r  <= out_chr_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // ring memory, read data always shows the entry at the next head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[tail_r] <= wr_data;
    end
    rd_data_r <= (wr_en && tail_r == head_nxt) ? wr_data : ring[head_nxt];
  end

  assign out_if.valid            = out_v_r;
  assign out_if.out_byte         = out_chr_r;
  assign out_if.last_of_run      = out_last_r;
  assign out_if.pending_overflow = out_ovf_r;

endmodule

// ===== rtl/deck_line_cleaner_unit.sv =====
// deck line cleaner top level: front end, work queue and back end
//
// Takes a text stream one byte per request and returns the cleaned text line
// by line. Outside quotes a double dash drops the rest of the line, a slash
// drops the rest but is kept; quoted text passes unchanged. Leading spaces,
// tabs and carriage returns are dropped, trailing ones are held in a ring of
// PENDING_DEPTH bytes and released only when kept text follows; a full ring
// releases its oldest byte early with pending_overflow set. Every line ends
// in a newline, and end_of_text closes an open line. last_of_run marks the
// final result byte of each input request; a request that yields nothing
// gives no result. Timing: the front end classifies a byte in the cycle it is
// accepted and queues a work list (up to four waiting), so input is taken
// whenever the queue has room. The back end sequencer emits one result byte
// a cycle while the output is not stalled, and it passes through a closing
// state for each request. The output is a register with a hold register in
// front of it, so the back end can produce one more result byte while a
// result waits to be taken and stalls on the next one. No clearing pass is
// needed after reset.
`include "deck_line_cleaner_unit_defines.svh"

module deck_line_cleaner_unit
  import dlc_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = DLC_PENDING_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  dlc_in_if.sink    in_if,
  dlc_out_if.source out_if
);

  // work queue between the two halves
  logic        q_push;
  logic        q_pop;
  dlc_rec_t    rec;
  dlc_rec_t    q_data;
  dlc_q_stat_t q_stat;

  // byte classification, quote and comment tracking
  dlc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_stat (q_stat),
    .push   (q_push),
    .rec    (rec)
  );

  dlc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (rec),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  // pending separator ring and result sequencing
  dlc_back #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_data (q_data),
    .pop    (q_pop),
    .out_if (out_if)
  );

  // queue must never overrun or underrun
  `DLC_NEVER(a_push_full, q_push && q_stat.full, "work queue written while full")
  `DLC_NEVER(a_pop_empty, q_pop && q_stat.empty, "work queue read while empty")
  // a dash released at line end only comes with a line close
  `DLC_IMPLIES(a_dash_endl, q_push && rec.dash3, rec.endl, "line-end dash without line close")
  // a queued work list leaves the queue non-empty next cycle unless popped
  `DLC_NEXT(a_push_seen, q_push && !q_pop, !q_stat.empty, "queued work list lost")

endmodule
